// File: design/rsame_pkg.sv
// Shared types and constants for the byte-wise RSA modular exponentiation block.
`timescale 1ns / 1ps

package rsame_pkg;

  localparam int MOD_WIDTH_DEF = 32;
  localparam int EXP_WIDTH     = 32;
  localparam int EXP_CNT_W     = $clog2(EXP_WIDTH);
  localparam int CIPHER_W      = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PUBLIC_EXPONENT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS         = 1'd1;

  localparam logic [EXP_WIDTH-1:0]  EXP_RESET = 32'd65537;
  localparam logic [CFG_DATA_W-1:0] MOD_RESET = 32'd3233;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       last_in;
  } in_req_t;

  typedef struct packed {
    logic [CIPHER_W-1:0] cipher_value;
    logic                last_out;
  } out_req_t;

endpackage

// File: design/rsa_byte_modexp_encrypt.sv
// Top level of the byte-wise RSA encryptor: c = m^e mod n per input byte.
//
// Input channel in_valid/in_stall/in_data carries one byte and its last-of-message
// flag; a request is taken when in_valid is high and in_stall is low. Output channel
// out_valid/out_stall/out_data returns the cipher word and the copied flag.
// The exponent and modulus are written through cfg_we/cfg_index/cfg_data while
// idle; the user must keep to this, as the block itself does not enforce it.
// Each byte is first reduced mod n by one modular multiplication by one, then
// left-to-right square-and-multiply runs over all 32 exponent bits. Every modular
// multiplication goes through one shared shift-and-add unit, which doubles for each
// bit of its second operand and adds the first operand for each set bit. An item
// takes (33 + popcount(e)) multiplications. A modulus below two skips them and
// gives zero. One byte is worked at a time and in_stall stays high while it runs.
// The finished result sits in an output register; a new byte may be accepted while
// it waits, and a stalled receiver only delays the hand-off of the next result.
// Reset clears the handshake state and loads e = 65537 and n = 3233.
`timescale 1ns / 1ps

module rsa_byte_modexp_encrypt #(
  parameter int MOD_WIDTH = rsame_pkg::MOD_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  rsame_pkg::in_req_t                       in_data,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output rsame_pkg::out_req_t                      out_data,
  input  logic                                     cfg_we,
  input  logic [rsame_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rsame_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import rsame_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_SQR  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam logic [MOD_WIDTH-1:0] ONE = MOD_WIDTH'(1);
  localparam logic [MOD_WIDTH-1:0] TWO = MOD_WIDTH'(2);

  state_t                 state;
  logic [EXP_WIDTH-1:0]   public_exponent;
  logic [CFG_DATA_W-1:0]  modulus;
  logic [MOD_WIDTH-1:0]   n_w;
  logic [MOD_WIDTH-1:0]   base;
  logic [MOD_WIDTH-1:0]   acc;
  logic [MOD_WIDTH-1:0]   op_a;
  logic [MOD_WIDTH-1:0]   op_b;
  logic [MOD_WIDTH-1:0]   mm_p;
  logic                   mm_go;
  logic                   mm_done;
  logic [EXP_CNT_W-1:0]   cnt;
  logic                   last;
  logic                   in_take;

  assign n_w      = MOD_WIDTH'(modulus);
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exponent <= EXP_RESET;
      modulus         <= MOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PUBLIC_EXPONENT: public_exponent <= EXP_WIDTH'(cfg_data);
        REG_MODULUS:         modulus         <= cfg_data;
      endcase
    end
  end

  rsame_mulmod #(.W(MOD_WIDTH)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .go      (mm_go),
    .a       (op_a),
    .b       (op_b),
    .n       (n_w),
    .done    (mm_done),
    .product (mm_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mm_go     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          mm_go <= in_take && (n_w >= TWO);
          if (in_take) begin
            state <= (n_w < TWO) ? S_DONE : S_RED;
          end
        end
        S_RED: begin
          mm_go <= mm_done;
          if (mm_done) begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          mm_go <= mm_done && (public_exponent[cnt] || cnt != '0);
          if (mm_done) begin
            if (public_exponent[cnt]) begin
              state <= S_MUL;
            end else if (cnt == '0) begin
              state <= S_DONE;
            end
          end
        end
        S_MUL: begin
          mm_go <= mm_done && (cnt != '0);
          if (mm_done) begin
            state <= (cnt == '0) ? S_DONE : S_SQR;
          end
        end
        S_DONE: begin
          mm_go <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          mm_go <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          last <= in_data.last_in;
          acc  <= '0;
          op_a <= ONE;
          op_b <= MOD_WIDTH'(in_data.message_byte);
        end
      end
      S_RED: begin
        if (mm_done) begin
          base <= mm_p;
          acc  <= ONE;
          op_a <= ONE;
          op_b <= ONE;
          cnt  <= EXP_CNT_W'(EXP_WIDTH - 1);
        end
      end
      S_SQR: begin
        if (mm_done) begin
          acc  <= mm_p;
          op_a <= mm_p;
          if (public_exponent[cnt]) begin
            op_b <= base;
          end else begin
            op_b <= mm_p;
            cnt  <= cnt - 1'b1;
          end
        end
      end
      S_MUL: begin
        if (mm_done) begin
          acc  <= mm_p;
          op_a <= mm_p;
          op_b <= mm_p;
          cnt  <= cnt - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_data.cipher_value <= CIPHER_W'(acc);
          out_data.last_out     <= last;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_RED || state == S_SQR || state == S_MUL))
    else $error("Multiplier result arrived with no operation pending.");

  assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_RED || state == S_DONE))
    else $error("Accepted request did not start processing.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && n_w >= TWO) |-> acc < n_w)
    else $error("Cipher value not reduced below the modulus.");

endmodule

// File: design/rsame_mulmod.sv
// Iterative modular multiplier: shift-and-add with one shared modular adder.
`timescale 1ns / 1ps

module rsame_mulmod #(
  parameter int W = rsame_pkg::MOD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] product
);
  import rsame_pkg::*;

  localparam int BW = (W > 1) ? $clog2(W) : 1;

  logic         busy;
  logic         phase_add;
  logic [BW-1:0] bcnt;
  logic [W-1:0] bsh;
  logic [W-1:0] acc;
  logic [W-1:0] a_r;
  logic [W-1:0] addend;
  logic [W:0]   sum;
  logic [W:0]   red;
  logic [W-1:0] acc_next;

  assign addend   = phase_add ? a_r : acc;
  assign sum      = {1'b0, acc} + {1'b0, addend};
  assign red      = sum - {1'b0, n};
  assign acc_next = (sum >= {1'b0, n}) ? red[W-1:0] : sum[W-1:0];
  assign product  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase_add <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (go) begin
        busy      <= 1'b1;
        phase_add <= 1'b0;
        done      <= 1'b0;
      end else if (busy) begin
        if (!phase_add && bsh[W-1]) begin
          phase_add <= 1'b1;
          done      <= 1'b0;
        end else begin
          phase_add <= 1'b0;
          if (bcnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            done <= 1'b0;
          end
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc  <= '0;
      a_r  <= a;
      bsh  <= b;
      bcnt <= BW'(W - 1);
    end else if (busy) begin
      acc <= acc_next;
      if (phase_add || !bsh[W-1]) begin
        bsh  <= bsh << 1;
        bcnt <= bcnt - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) go |-> !busy)
    else $error("Multiplier started while busy.");

  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("Multiplier finished without a done pulse.");

  assert property (@(posedge clk) disable iff (rst)
    (busy && !go && n >= W'(2)) |-> acc < n)
    else $error("Multiplier accumulator left the residue range.");

endmodule
